>>> rtl/core/iopd_pkg.sv
`timescale 1ns / 1ps

package iopd_pkg;

   localparam int ADDRESS_BITS = 32;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IO_PORT_LIMIT = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_USER_ADDRESS_LIMIT = 1'b1;

   localparam logic [16:0] IO_PORT_LIMIT_RESET = 17'h10000;
   localparam logic [31:0] USER_ADDRESS_LIMIT_RESET = 32'hc000_0000;

   // opcodes
   localparam logic [7:0] OP_IN_AL_DX = 8'hec;
   localparam logic [7:0] OP_IN_EAX_DX = 8'hed;
   localparam logic [7:0] OP_OUT_DX_AL = 8'hee;
   localparam logic [7:0] OP_OUT_DX_EAX = 8'hef;
   localparam logic [7:0] OP_INSB = 8'h6c;
   localparam logic [7:0] OP_INSD = 8'h6d;
   localparam logic [7:0] OP_OUTSB = 8'h6e;
   localparam logic [7:0] OP_OUTSD = 8'h6f;
   localparam logic [7:0] OP_IN_AL_IMM = 8'he4;
   localparam logic [7:0] OP_IN_EAX_IMM = 8'he5;
   localparam logic [7:0] OP_OUT_IMM_AL = 8'he6;
   localparam logic [7:0] OP_OUT_IMM_EAX = 8'he7;
   localparam logic [7:0] OP_CLI = 8'hfa;
   localparam logic [7:0] OP_STI = 8'hfb;
   localparam logic [7:0] PFX_OPSIZE = 8'h66;
   localparam logic [7:0] PFX_REP = 8'hf3;

   // log2 of ports touched
   localparam logic [4:0] SIZE_BYTE = 5'd0;
   localparam logic [4:0] SIZE_WORD = 5'd1;
   localparam logic [4:0] SIZE_DWORD = 5'd2;
   localparam logic [4:0] SIZE_ALL_PORTS = 5'd16;

   typedef struct packed {
      logic        recognized;
      logic [15:0] port_number;
      logic [4:0]  size_code;
   } iopd_result_type;

endpackage

>>> rtl/core/iopd_req_if.sv
`timescale 1ns / 1ps

interface iopd_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instr_address;
   logic [7:0]  byte_zero;
   logic [7:0]  byte_one;
   logic [7:0]  byte_two;
   logic [15:0] dx_value;

   modport source (
      output valid, instr_address, byte_zero, byte_one, byte_two, dx_value,
      input  ready
   );
   modport sink (
      input  valid, instr_address, byte_zero, byte_one, byte_two, dx_value,
      output ready
   );
endinterface

>>> rtl/core/iopd_rsp_if.sv
`timescale 1ns / 1ps

interface iopd_rsp_if;
   logic        valid;
   logic        ready;
   logic        recognized;
   logic [15:0] port_number;
   logic [4:0]  size_code;

   modport source (
      output valid, recognized, port_number, size_code,
      input  ready
   );
   modport sink (
      input  valid, recognized, port_number, size_code,
      output ready
   );
endinterface

>>> rtl/core/iopd_decode.sv
`timescale 1ns / 1ps

module iopd_decode
   import iopd_pkg::*;
(
   input  logic [31:0]     instr_address,
   input  logic [7:0]      byte_zero,
   input  logic [7:0]      byte_one,
   input  logic [7:0]      byte_two,
   input  logic [15:0]     dx_value,
   input  logic [16:0]     io_port_limit,
   input  logic [31:0]     user_address_limit,
   output iopd_result_type result
);

   logic [ADDRESS_BITS-1:0] addr;
   logic [ADDRESS_BITS-1:0] limit_two;
   logic [ADDRESS_BITS-1:0] limit_three;
   logic                    two_byte_ok;
   logic                    three_byte_ok;
   logic                    dx_fits_word;
   logic                    dx_fits_dword;
   logic                    b1_fits_dword;
   logic                    b2_fits_word;
   logic                    prefix_pair;
   logic                    rep_path;
   logic                    hit;
   logic [15:0]             port;
   logic [4:0]              size;

   assign addr = ADDRESS_BITS'(instr_address);
   assign limit_two = ADDRESS_BITS'(user_address_limit) - ADDRESS_BITS'(1);
   assign limit_three = ADDRESS_BITS'(user_address_limit) - ADDRESS_BITS'(2);
   assign two_byte_ok = addr < limit_two;
   assign three_byte_ok = addr < limit_three;

   assign dx_fits_word = ({1'b0, dx_value} + 17'd2) <= io_port_limit;
   assign dx_fits_dword = ({1'b0, dx_value} + 17'd4) <= io_port_limit;
   assign b1_fits_dword = ({9'd0, byte_one} + 17'd4) <= io_port_limit;
   assign b2_fits_word = ({9'd0, byte_two} + 17'd2) <= io_port_limit;

   assign prefix_pair = ((byte_zero == PFX_REP) && (byte_one == PFX_OPSIZE)) ||
                        ((byte_zero == PFX_OPSIZE) && (byte_one == PFX_REP));

   always_comb begin
      hit = 1'b0;
      port = 16'd0;
      size = SIZE_BYTE;
      rep_path = 1'b0;
      case (byte_zero)
         OP_IN_AL_DX, OP_INSB, OP_OUT_DX_AL, OP_OUTSB: begin
            hit = 1'b1;
            port = dx_value;
            size = SIZE_BYTE;
         end
         OP_IN_EAX_DX, OP_INSD, OP_OUT_DX_EAX, OP_OUTSD: begin
            hit = dx_fits_dword;
            port = dx_value;
            size = SIZE_DWORD;
         end
         OP_CLI, OP_STI: begin
            hit = 1'b1;
            port = 16'd0;
            size = SIZE_ALL_PORTS;
         end
         OP_IN_AL_IMM, OP_OUT_IMM_AL: begin
            hit = two_byte_ok;
            port = {8'd0, byte_one};
            size = SIZE_BYTE;
         end
         OP_IN_EAX_IMM, OP_OUT_IMM_EAX: begin
            hit = two_byte_ok && b1_fits_dword;
            port = {8'd0, byte_one};
            size = SIZE_DWORD;
         end
         PFX_OPSIZE: begin
            case (byte_one)
               OP_IN_EAX_DX, OP_OUT_DX_EAX, OP_INSD, OP_OUTSD: begin
                  hit = two_byte_ok && dx_fits_word;
                  port = dx_value;
                  size = SIZE_WORD;
               end
               OP_IN_EAX_IMM, OP_OUT_IMM_EAX: begin
                  hit = two_byte_ok && b2_fits_word;
                  port = {8'd0, byte_two};
                  size = SIZE_WORD;
               end
               // other forms continue as if the prefix were REP
               default: rep_path = 1'b1;
            endcase
         end
         PFX_REP: rep_path = 1'b1;
         default: ;
      endcase

      if (rep_path) begin
         case (byte_one)
            OP_INSB, OP_OUTSB: begin
               hit = two_byte_ok;
               port = dx_value;
               size = SIZE_BYTE;
            end
            OP_INSD, OP_OUTSD: begin
               hit = two_byte_ok && dx_fits_dword;
               port = dx_value;
               size = SIZE_DWORD;
            end
            default: begin
               hit = two_byte_ok && three_byte_ok && prefix_pair &&
                     ((byte_two == OP_INSD) || (byte_two == OP_OUTSD)) && dx_fits_word;
               port = dx_value;
               size = SIZE_WORD;
            end
         endcase
      end
   end

   assign result.recognized = hit;
   assign result.port_number = hit ? port : 16'd0;
   assign result.size_code = hit ? size : SIZE_BYTE;

endmodule

>>> rtl/core/x86_io_instruction_port_decode.sv
`timescale 1ns / 1ps

// Port I/O instruction decoder.
// req_channel carries one faulting instruction per transaction: its address,
// its first three bytes and the low half of DX. rsp_channel returns one
// transaction per request: a hit flag, the first port and the log2 access
// size (16 for CLI/STI, meaning the whole port space). A miss reports zero
// port and size.
// Both channels use valid/ready; a transaction moves when both are high.
// The request is registered, decoded in one combinational pass, and the result
// is registered before response valid rises. One transaction per cycle is
// sustained while rsp_channel does not stall; the decode stage holds a single
// input register and a single result register.
// When rsp_channel stalls, the result register holds and the input register
// keeps accepting until it is also full, then req_channel.ready drops.
// csr_* writes the port limit (index 0) and the user address limit (index 1);
// write them only while no transaction is in flight.
// Reset (synchronous) empties both stages and restores the limits to 0x10000
// and 0xC0000000.
module x86_io_instruction_port_decode
   import iopd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   iopd_req_if.sink                  req_channel,
   iopd_rsp_if.source                rsp_channel,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   logic [16:0]     io_port_limit_ff, io_port_limit_in;
   logic [31:0]     user_address_limit_ff, user_address_limit_in;

   logic            in_valid_ff, in_valid_in;
   logic [31:0]     instr_address_ff;
   logic [7:0]      byte_zero_ff;
   logic [7:0]      byte_one_ff;
   logic [7:0]      byte_two_ff;
   logic [15:0]     dx_value_ff;

   logic            out_valid_ff, out_valid_in;
   iopd_result_type result_ff;
   iopd_result_type decoded;

   logic            out_advance;
   logic            in_take;

   assign out_advance = !out_valid_ff || rsp_channel.ready;
   assign req_channel.ready = !in_valid_ff || out_advance;
   assign in_take = req_channel.valid && req_channel.ready;

   always_comb begin
      io_port_limit_in = io_port_limit_ff;
      user_address_limit_in = user_address_limit_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_IO_PORT_LIMIT: io_port_limit_in = csr_write_data[16:0];
            CSR_USER_ADDRESS_LIMIT: user_address_limit_in = csr_write_data[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_channel.ready) begin
         in_valid_in = req_channel.valid;
      end
      out_valid_in = out_valid_ff;
      if (out_advance) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         io_port_limit_ff <= IO_PORT_LIMIT_RESET;
         user_address_limit_ff <= USER_ADDRESS_LIMIT_RESET;
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         io_port_limit_ff <= io_port_limit_in;
         user_address_limit_ff <= user_address_limit_in;
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         instr_address_ff <= req_channel.instr_address;
         byte_zero_ff <= req_channel.byte_zero;
         byte_one_ff <= req_channel.byte_one;
         byte_two_ff <= req_channel.byte_two;
         dx_value_ff <= req_channel.dx_value;
      end
      if (out_advance && in_valid_ff) begin
         result_ff <= decoded;
      end
   end

   iopd_decode u_decode (
      .instr_address      (instr_address_ff),
      .byte_zero          (byte_zero_ff),
      .byte_one           (byte_one_ff),
      .byte_two           (byte_two_ff),
      .dx_value           (dx_value_ff),
      .io_port_limit      (io_port_limit_ff),
      .user_address_limit (user_address_limit_ff),
      .result             (decoded)
   );

   assign rsp_channel.valid = out_valid_ff;
   assign rsp_channel.recognized = result_ff.recognized;
   assign rsp_channel.port_number = result_ff.port_number;
   assign rsp_channel.size_code = result_ff.size_code;

endmodule
